@@ design/srsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared types and constants for the stepper ramp step generator: request
// payload structs, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package srsg_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned BASE_W   = 15;
    localparam int unsigned RAMP_W   = 12;
    localparam int unsigned DECEL_W  = 15;
    localparam int unsigned PULSE_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DEFAULT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH    = 2'd2;

    // Reset values
    localparam logic [RAMP_W-1:0]  RAMP_DEFAULT_RST   = 12'd1500;
    localparam logic [DECEL_W-1:0] DECEL_DISTANCE_RST = 15'd500;
    localparam logic [PULSE_W-1:0] PULSE_WIDTH_RST    = 16'd100;

    // Ramp shrink per step
    localparam logic [RAMP_W-1:0]  RAMP_SHRINK        = 12'd2;

    typedef struct packed {
        logic [TIME_W-1:0]        now_us;
        logic signed [POS_W-1:0]  target_pos;
        logic [BASE_W-1:0]        base_interval;
    } in_item_t;

    typedef struct packed {
        logic                     step_level;
        logic                     direction;
        logic signed [POS_W-1:0]  position;
        logic                     at_target;
    } out_item_t;

endpackage : srsg_pkg
`default_nettype wire

@@ design/stepper_ramp_step_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator
// Single-axis step/direction generator with a linear ramp delay.
// ----------------------------------------------------------------------------
// Each request carries the current microsecond time, a target position and a
// base step interval, and produces exactly one result: step pulse level,
// direction, axis position after the request and an at-target flag. A step is
// taken when the wrapped time since the last step reaches base_interval plus
// the ramp delay; the ramp delay shrinks by two per step while far from the
// target and grows by one up to ramp_default otherwise, and snaps back to
// ramp_default on arrival. Throughput is one request per clock while m_ready
// is high. A request is captured in the input register when accepted,
// evaluated by one pass of compare and add logic as it moves into the
// result register, and shown on m_data from then on. The axis state
// registers update on that same edge, which lets the next request follow.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [srsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [srsg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire srsg_pkg::in_item_t              s_data,
    // Result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output srsg_pkg::out_item_t                  m_data
);
    import srsg_pkg::*;

    // Configuration registers
    logic [RAMP_W-1:0]  ramp_default_reg;
    logic [DECEL_W-1:0] decel_distance_reg;
    logic [PULSE_W-1:0] pulse_width_reg;

    // Axis state
    logic signed [POS_W-1:0] position_reg, position_next;
    logic [TIME_W-1:0]       last_time_reg, last_time_next;
    logic [RAMP_W-1:0]       ramp_reg, ramp_next;
    logic                    pulse_reg, pulse_next;
    logic                    dir_reg, dir_next;

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    // Step evaluation
    logic [TIME_W-1:0]        elapsed;
    logic [BASE_W:0]          threshold;
    logic                     due;
    logic                     move_down;
    logic                     move_up;
    logic signed [POS_W:0]    remaining;
    logic [RAMP_W-1:0]        ramp_stepped;
    logic                     advance;

    // ------------------------------------------------------------------
    // Handshake: advance the input stage whenever the result slot is free
    // or being drained this cycle.
    // ------------------------------------------------------------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Step rule
    // ------------------------------------------------------------------
    always_comb begin
        elapsed   = in_data_reg.now_us - last_time_reg;
        threshold = {1'b0, in_data_reg.base_interval} + {{(BASE_W+1-RAMP_W){1'b0}}, ramp_reg};
        due       = elapsed >= {{(TIME_W-BASE_W-1){1'b0}}, threshold};
        move_down = in_data_reg.target_pos < position_reg;
        move_up   = in_data_reg.target_pos > position_reg;

        position_next = position_reg;
        last_time_next = last_time_reg;
        ramp_next = ramp_reg;
        pulse_next = pulse_reg;
        dir_next = dir_reg;
        remaining = '0;
        ramp_stepped = ramp_reg;

        if (move_down) begin
            position_next = position_reg - 16'sd1;
            remaining = {position_next[POS_W-1], position_next}
                      - {in_data_reg.target_pos[POS_W-1], in_data_reg.target_pos};
        end else begin
            position_next = position_reg + 16'sd1;
            remaining = {in_data_reg.target_pos[POS_W-1], in_data_reg.target_pos}
                      - {position_next[POS_W-1], position_next};
        end

        // Shrink while far from target, else creep back toward default
        if ((ramp_reg != '0) && (remaining > $signed({2'b00, decel_distance_reg}))) begin
            ramp_stepped = (ramp_reg >= RAMP_SHRINK) ? ramp_reg - RAMP_SHRINK : '0;
        end else if (ramp_reg < ramp_default_reg) begin
            ramp_stepped = ramp_reg + 12'd1;
        end

        if (due) begin
            if (move_down || move_up) begin
                dir_next   = move_down;
                pulse_next = 1'b1;
                ramp_next  = ramp_stepped;
            end else begin
                position_next = position_reg;
            end
            last_time_next = in_data_reg.now_us;
            if (position_next == in_data_reg.target_pos) begin
                ramp_next = ramp_default_reg;
            end
        end else begin
            position_next = position_reg;
            // Drop the pulse once the width has run out
            if (elapsed > {{(TIME_W-PULSE_W){1'b0}}, pulse_width_reg}) begin
                pulse_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_default_reg   <= RAMP_DEFAULT_RST;
            decel_distance_reg <= DECEL_DISTANCE_RST;
            pulse_width_reg    <= PULSE_WIDTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RAMP_DEFAULT:   ramp_default_reg   <= cfg_wdata[RAMP_W-1:0];
                REG_DECEL_DISTANCE: decel_distance_reg <= cfg_wdata[DECEL_W-1:0];
                REG_PULSE_WIDTH:    pulse_width_reg    <= cfg_wdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Axis state: update together with the result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            last_time_reg <= '0;
            ramp_reg      <= RAMP_DEFAULT_RST;
            pulse_reg     <= 1'b0;
            dir_reg       <= 1'b0;
        end else if (advance) begin
            position_reg  <= position_next;
            last_time_reg <= last_time_next;
            ramp_reg      <= ramp_next;
            pulse_reg     <= pulse_next;
            dir_reg       <= dir_next;
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold the request until it is evaluated
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg.step_level <= pulse_next;
            out_data_reg.direction  <= dir_next;
            out_data_reg.position   <= position_next;
            out_data_reg.at_target  <= (position_next == in_data_reg.target_pos);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Position moves by at most one count per request
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (position_reg == $past(position_reg))
                 || (position_reg == $past(position_reg) + 16'sd1)
                 || (position_reg == $past(position_reg) - 16'sd1))
        else $error("position jumped by more than one step");

    // Arrival on target restores the default ramp delay
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && due && (position_next == in_data_reg.target_pos))
            |=> (ramp_reg == $past(ramp_default_reg)))
        else $error("ramp delay not restored at target");

    // A request that is not due leaves position and step time alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !due) |=> $stable(position_reg) && $stable(last_time_reg))
        else $error("axis state changed without a due step");

    // A stalled input stage must not take a new request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !s_ready)
        else $error("request accepted while input stage is stalled");

endmodule : stepper_ramp_step_generator
`default_nettype wire
